[sv/ttb_pkg.sv]
// Package for the triangle tangent and bitangent block: widths and divider control.
package ttb_pkg;
    localparam int POS_W_DEF = 32;
    localparam int TEX_W_DEF = 24;
    localparam int OUT_W     = 32;
    localparam int FRAC_SHIFT = 16;

    // Divider operation request.
    typedef struct packed {
        logic start;
    } div_ctl_t;
endpackage

[sv/triangle_tangent_bitangent.sv]
// Top level of the per-triangle tangent and bitangent unit.
// Usage:
//   The input channel takes one triangle corner per request (position in
//   Q16.16, texture coordinate in Q8.16), corners in index order. The first
//   two corners are stored. The third corner starts the sequencer and the
//   input is not ready until its result has left.
//   Result channel: one request per triangle with tangent and bitangent in
//   Q16.16, a saturated flag and a degenerate flag (zero UV determinant gives
//   zero vectors).
//   Sequence after the third corner: fourteen products on the one multiplier,
//   then six divisions on the one serial divider, then the result is loaded
//   for output. A zero determinant skips the remaining products and the
//   divisions. The next corner is taken from the cycle after the result leaves.
//   Reset clears the corner count and handshake state; stored corners are
//   undefined until written.
//   When the receiver stalls, the result holds in its output register and
//   the input stays not ready until it is taken.
module triangle_tangent_bitangent
    import ttb_pkg::*;
#(
    parameter int POSITION_WIDTH = POS_W_DEF,
    parameter int TEXCOORD_WIDTH = TEX_W_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [POSITION_WIDTH-1:0] pos_x,
    input  logic signed [POSITION_WIDTH-1:0] pos_y,
    input  logic signed [POSITION_WIDTH-1:0] pos_z,
    input  logic signed [TEXCOORD_WIDTH-1:0] tex_u,
    input  logic signed [TEXCOORD_WIDTH-1:0] tex_v,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [OUT_W-1:0]          tangent_x,
    output logic signed [OUT_W-1:0]          tangent_y,
    output logic signed [OUT_W-1:0]          tangent_z,
    output logic signed [OUT_W-1:0]          bitangent_x,
    output logic signed [OUT_W-1:0]          bitangent_y,
    output logic signed [OUT_W-1:0]          bitangent_z,
    output logic                             degenerate,
    output logic                             saturated
);
    localparam int PW = POSITION_WIDTH + 1;        // delta widths
    localparam int TW = TEXCOORD_WIDTH + 1;
    localparam int MA = (PW > TW) ? PW : TW;       // multiplier a width
    localparam int PRW = MA + TW;                  // product width
    localparam int SW = PRW + 1;                   // sum of two products
    localparam int NW = SW + FRAC_SHIFT;           // shifted numerator
    localparam int QW = NW;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_MWAIT = 4'd2;
    localparam logic [3:0] S_DIV   = 4'd3;
    localparam logic [3:0] S_DWAIT = 4'd4;
    localparam logic [3:0] S_OUT   = 4'd5;

    logic [3:0] st_reg, st_next;
    logic [1:0] cnt_reg;
    logic [3:0] step_reg;       // product step 0..10 / quotient index 0..5
    logic       half_reg;       // second product of a determinant or numerator product pair

    logic signed [PW-1:0] p0_reg [3], p1_reg [3], dp1_reg [3], dp2_reg [3];
    logic signed [TW-1:0] t0_reg [2], t1_reg [2];
    logic signed [TW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [SW-1:0] acc_reg;
    logic signed [SW-1:0] num_reg [6];
    logic signed [SW-1:0] det_reg;
    logic signed [OUT_W-1:0] res_reg [6];
    logic sat_reg, deg_reg, ov_reg;

    logic in_acc;
    assign in_ready = (st_reg == S_IDLE) && !ov_reg;
    assign in_acc = in_valid && in_ready;

    // operand select for the shared multiplier
    logic signed [MA-1:0] ma;
    logic signed [TW-1:0] mb;
    logic signed [PRW-1:0] mp;
    logic [1:0] comp;
    assign comp = 2'((step_reg - 4'd1) >> 2);

    always_comb
    begin
        ma = '0;
        mb = '0;
        if (step_reg == 4'd0)
        begin
            ma = half_reg ? MA'(dv1_reg) : MA'(du1_reg);
            mb = half_reg ? du2_reg : dv2_reg;
        end
        else
        begin
            case (2'((step_reg - 4'd1) & 4'd3))
                2'd0:
                begin
                    ma = half_reg ? MA'(dp2_reg[comp]) : MA'(dp1_reg[comp]);
                    mb = half_reg ? dv1_reg : dv2_reg;
                end
                2'd1:
                begin
                    ma = half_reg ? MA'(dp1_reg[comp]) : MA'(dp2_reg[comp]);
                    mb = half_reg ? du2_reg : du1_reg;
                end
                default:
                begin
                    ma = '0;
                    mb = '0;
                end
            endcase
        end
    end

    ttb_mul #(.AW(MA), .BW(TW)) u_mul
    (
        .clk (clk),
        .a   (ma),
        .b   (mb),
        .p   (mp)
    );

    // divider on magnitudes
    div_ctl_t dctl;
    logic dbusy;
    logic [QW-1:0] dq;
    logic [2:0] qi;
    logic signed [SW-1:0] nsel;
    logic [NW-1:0] nmag;
    logic [SW-1:0] dmag;
    logic qneg;
    assign qi = step_reg[2:0];
    assign nsel = num_reg[qi];
    assign nmag = {(nsel[SW-1] ? SW'(-nsel) : SW'(nsel)), {FRAC_SHIFT{1'b0}}};
    assign dmag = det_reg[SW-1] ? SW'(-det_reg) : SW'(det_reg);
    assign qneg = nsel[SW-1] ^ det_reg[SW-1];
    assign dctl.start = (st_reg == S_DIV);

    ttb_div #(.NW(NW), .DW(SW)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (dctl),
        .num   (nmag),
        .den   (dmag),
        .busy  (dbusy),
        .quo   (dq)
    );

    // saturate a quotient magnitude
    logic [QW-1:0] lim;
    logic          qsat;
    logic signed [OUT_W-1:0] qout;
    assign lim  = qneg ? QW'(33'h080000000) : QW'(33'h07FFFFFFF);
    assign qsat = dq > lim;
    always_comb
    begin
        if (qsat)
        begin
            qout = qneg ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
        end
        else
        begin
            qout = qneg ? OUT_W'(-dq[OUT_W-1:0]) : dq[OUT_W-1:0];
        end
    end

    // determinant zero test on the just-formed sum
    logic signed [SW-1:0] sum;
    logic det_zero_n;
    assign sum = acc_reg - SW'(mp);
    assign det_zero_n = (sum == '0);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (in_acc && cnt_reg == 2'd2) st_next = S_MUL;
            S_MUL:   st_next = S_MWAIT;
            S_MWAIT:
            begin
                if (half_reg && (step_reg == 4'd0 || (step_reg & 4'd3) == 4'd2) &&
                    step_reg != 4'd0 && step_reg >= 4'd10)
                begin
                    st_next = S_DIV;
                end
                else if (half_reg && step_reg == 4'd0 && det_zero_n)
                begin
                    st_next = S_OUT;
                end
                else
                begin
                    st_next = S_MUL;
                end
            end
            S_DIV:   st_next = S_DWAIT;
            S_DWAIT:
            begin
                if (!dbusy)
                begin
                    st_next = (step_reg == 4'd5) ? S_OUT : S_DIV;
                end
            end
            S_OUT:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            cnt_reg  <= 2'd0;
            ov_reg   <= 1'b0;
            step_reg <= '0;
            half_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (in_acc)
            begin
                cnt_reg <= (cnt_reg == 2'd2) ? 2'd0 : cnt_reg + 2'd1;
                step_reg <= '0;
                half_reg <= 1'b0;
            end
            if (st_reg == S_MWAIT)
            begin
                half_reg <= !half_reg;
                if (half_reg)
                begin
                    if (st_next == S_DIV)
                    begin
                        step_reg <= '0;
                    end
                    else if (step_reg == 4'd0)
                    begin
                        step_reg <= 4'd1;
                    end
                    else
                    begin
                        step_reg <= ((step_reg & 4'd3) == 4'd2) ? step_reg + 4'd3
                                                                 : step_reg + 4'd1;
                    end
                end
            end
            if (st_reg == S_DWAIT && !dbusy)
            begin
                step_reg <= step_reg + 4'd1;
            end
            if (st_reg == S_OUT)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_valid && out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            case (cnt_reg)
                2'd0:
                begin
                    p0_reg[0] <= PW'(pos_x);
                    p0_reg[1] <= PW'(pos_y);
                    p0_reg[2] <= PW'(pos_z);
                    t0_reg[0] <= TW'(tex_u);
                    t0_reg[1] <= TW'(tex_v);
                end
                2'd1:
                begin
                    p1_reg[0] <= PW'(pos_x);
                    p1_reg[1] <= PW'(pos_y);
                    p1_reg[2] <= PW'(pos_z);
                    t1_reg[0] <= TW'(tex_u);
                    t1_reg[1] <= TW'(tex_v);
                end
                default:
                begin
                    dp1_reg[0] <= p1_reg[0] - p0_reg[0];
                    dp1_reg[1] <= p1_reg[1] - p0_reg[1];
                    dp1_reg[2] <= p1_reg[2] - p0_reg[2];
                    dp2_reg[0] <= PW'(pos_x) - p0_reg[0];
                    dp2_reg[1] <= PW'(pos_y) - p0_reg[1];
                    dp2_reg[2] <= PW'(pos_z) - p0_reg[2];
                    du1_reg <= t1_reg[0] - t0_reg[0];
                    dv1_reg <= t1_reg[1] - t0_reg[1];
                    du2_reg <= TW'(tex_u) - t0_reg[0];
                    dv2_reg <= TW'(tex_v) - t0_reg[1];
                    sat_reg <= 1'b0;
                    deg_reg <= 1'b0;
                end
            endcase
        end
        if (st_reg == S_MWAIT)
        begin
            if (!half_reg)
            begin
                acc_reg <= SW'(mp);
            end
            else if (step_reg == 4'd0)
            begin
                det_reg <= sum;
                if (det_zero_n)
                begin
                    deg_reg <= 1'b1;
                    for (int i = 0; i < 6; i++)
                    begin
                        res_reg[i] <= '0;
                    end
                end
            end
            else
            begin
                // tangent then bitangent numerator for one component
                num_reg[3'(((step_reg - 4'd1) >> 2)) + (((step_reg - 4'd1) & 4'd3) == 4'd1
                        ? 3'd3 : 3'd0)] <= sum;
            end
        end
        if (st_reg == S_DWAIT && !dbusy)
        begin
            res_reg[qi] <= qout;
            if (qsat)
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign tangent_x   = res_reg[0];
    assign tangent_y   = res_reg[1];
    assign tangent_z   = res_reg[2];
    assign bitangent_x = res_reg[3];
    assign bitangent_y = res_reg[4];
    assign bitangent_z = res_reg[5];
    assign degenerate  = deg_reg;
    assign saturated   = sat_reg;
endmodule

[sv/ttb_mul.sv]
// Shared signed multiplier with a registered product.
module ttb_mul
    import ttb_pkg::*;
#(
    parameter int AW = 33,
    parameter int BW = 25
)
(
    input  logic                    clk,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);
    always_ff @(posedge clk)
    begin
        p <= a * b;
    end
endmodule

[sv/ttb_div.sv]
// Restoring divider, one quotient bit per cycle, magnitudes in and out.
module ttb_div
    import ttb_pkg::*;
#(
    parameter int NW = 80,
    parameter int DW = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  div_ctl_t      ctl,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] n_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   sh;
    logic [DW+1:0] diff;

    assign sh   = {r_reg[DW-1:0], n_reg[NW-1]};
    assign diff = {1'b0, sh} - {2'b00, d_reg};
    assign busy = (cnt_reg != '0);
    assign quo  = n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.start)
        begin
            cnt_reg <= CW'(NW);
        end
        else if (busy)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            n_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy)
        begin
            if (!diff[DW+1])
            begin
                r_reg <= diff[DW:0];
                n_reg <= {n_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= sh;
                n_reg <= {n_reg[NW-2:0], 1'b0};
            end
        end
    end
endmodule

[sv/ttb_checker.sv]
// Port-level checker for the tangent and bitangent block, bound to the top level.
module ttb_checker
    import ttb_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic degenerate,
    input logic saturated
);
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("request withdrawn before it was taken");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready with a pending result");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(degenerate && saturated))
        else $error("degenerate result marked saturated");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result repeated");
endmodule

bind triangle_tangent_bitangent ttb_checker u_ttb_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .degenerate (degenerate),
    .saturated  (saturated)
);

[verif/triangle_tangent_bitangent_tb.sv]
// Triangle tangent and bitangent testbench: directed and random corners checked by a scoreboard.
module triangle_tangent_bitangent_tb;
    import ttb_pkg::*;

    localparam int PW = POS_W_DEF;
    localparam int TW = TEX_W_DEF;

    typedef struct packed {
        logic signed [OUT_W-1:0] tx, ty, tz, bx, by, bz;
        logic                    degen;
        logic                    sat;
    } tb_result_t;

    // Shadow of the block: stores two corners, predicts on the third.
    class tangent_scoreboard;
        int                  corner_idx;
        logic signed [PW-1:0] p0 [3];
        logic signed [PW-1:0] p1 [3];
        logic signed [TW-1:0] t0 [2];
        logic signed [TW-1:0] t1 [2];
        tb_result_t          pending [$];
        int                  errors;

        function new();
            corner_idx = 0;
            errors = 0;
        endfunction

        // num * 2^16 / det, truncated toward zero, clipped to 32 bits
        function logic signed [OUT_W-1:0] scaled_quot(logic signed [127:0] num,
                                                      logic signed [127:0] det,
                                                      inout logic sat);
            logic         neg;
            logic [127:0] n, d, q, lim;
            neg = num[127] ^ det[127];
            n = num[127] ? -num : num;
            d = det[127] ? -det : det;
            q = (n << FRAC_SHIFT) / d;
            lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
            if (q > lim)
            begin
                q = lim;
                sat = 1'b1;
            end
            if (neg)
                q = -q;
            return q[OUT_W-1:0];
        endfunction

        function void note_corner(logic signed [PW-1:0] p [3], logic signed [TW-1:0] t [2]);
            logic signed [127:0] du1, dv1, du2, dv2, det, dp1, dp2, tn, bn;
            logic signed [OUT_W-1:0] tv [3];
            logic signed [OUT_W-1:0] bv [3];
            tb_result_t r;
            logic sat;
            if (corner_idx == 0)
            begin
                p0 = p;
                t0 = t;
                corner_idx = 1;
                return;
            end
            if (corner_idx == 1)
            begin
                p1 = p;
                t1 = t;
                corner_idx = 2;
                return;
            end
            corner_idx = 0;
            du1 = 128'(t1[0]) - 128'(t0[0]);
            dv1 = 128'(t1[1]) - 128'(t0[1]);
            du2 = 128'(t[0]) - 128'(t0[0]);
            dv2 = 128'(t[1]) - 128'(t0[1]);
            det = du1 * dv2 - dv1 * du2;
            r = '0;
            sat = 1'b0;
            if (det == 0)
                r.degen = 1'b1;
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    dp1 = 128'(p1[i]) - 128'(p0[i]);
                    dp2 = 128'(p[i]) - 128'(p0[i]);
                    tn = dp1 * dv2 - dp2 * dv1;
                    bn = dp2 * du1 - dp1 * du2;
                    tv[i] = scaled_quot(tn, det, sat);
                    bv[i] = scaled_quot(bn, det, sat);
                end
                r.tx = tv[0]; r.ty = tv[1]; r.tz = tv[2];
                r.bx = bv[0]; r.by = bv[1]; r.bz = bv[2];
                r.sat = sat;
            end
            pending = {pending, r};
        endfunction

        function void check_result(tb_result_t got);
            tb_result_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.tx !== e.tx) begin $error("tangent_x exp %h got %h", e.tx, got.tx); errors++; end
            if (got.ty !== e.ty) begin $error("tangent_y exp %h got %h", e.ty, got.ty); errors++; end
            if (got.tz !== e.tz) begin $error("tangent_z exp %h got %h", e.tz, got.tz); errors++; end
            if (got.bx !== e.bx) begin $error("bitangent_x exp %h got %h", e.bx, got.bx); errors++; end
            if (got.by !== e.by) begin $error("bitangent_y exp %h got %h", e.by, got.by); errors++; end
            if (got.bz !== e.bz) begin $error("bitangent_z exp %h got %h", e.bz, got.bz); errors++; end
            if (got.degen !== e.degen)
            begin
                $error("degenerate exp %b got %b", e.degen, got.degen);
                errors++;
            end
            if (got.sat !== e.sat)
            begin
                $error("saturated exp %b got %b", e.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [PW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [TW-1:0] tex_u = '0, tex_v = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [OUT_W-1:0] tangent_x, tangent_y, tangent_z;
    logic signed [OUT_W-1:0] bitangent_x, bitangent_y, bitangent_z;
    logic degenerate, saturated;

    // Idle rates in percent; the stimulus process moves through the phases.
    int send_idle_pct = 35;
    int recv_idle_pct = 69;
    // Long hold-off on the result side, counted down in the receiver process.
    int hold_cycles = 0;
    bit hold_req = 1'b0;
    bit hold_taken = 1'b0;
    bit stim_done = 1'b0;

    tangent_scoreboard sb = new();

    triangle_tangent_bitangent u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .tex_u(tex_u), .tex_v(tex_v),
        .out_valid(out_valid), .out_ready(out_ready),
        .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
        .bitangent_x(bitangent_x), .bitangent_y(bitangent_y), .bitangent_z(bitangent_z),
        .degenerate(degenerate), .saturated(saturated)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Field picks that favor the extremes and small values now and then.
    function automatic logic [PW-1:0] pick_pos();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(PW-1){1'b0}}};
            1: return {1'b0, {(PW-1){1'b1}}};
            2: return PW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            default: return PW'($urandom());
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_tex();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(TW-1){1'b0}}};
            1: return {1'b0, {(TW-1){1'b1}}};
            2: return TW'($urandom_range(0, 15));
            3: return TW'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
            default: return TW'($urandom());
        endcase
    endfunction

    // Offers one corner, holding it until the block takes it. Valid drops only
    // when the sender idles, so back-to-back corners keep it high.
    task automatic send_corner(logic [PW-1:0] x, logic [PW-1:0] y, logic [PW-1:0] z,
                               logic [TW-1:0] u, logic [TW-1:0] v);
        logic signed [PW-1:0] p [3];
        logic signed [TW-1:0] t [2];
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pos_x <= x; pos_y <= y; pos_z <= z;
        tex_u <= u; tex_v <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        p[0] = x; p[1] = y; p[2] = z;
        t[0] = u; t[1] = v;
        sb.note_corner(p, t);
    endtask

    task automatic send_random_triangles(int count);
        logic [TW-1:0] u0, v0;
        for (int k = 0; k < count; k++)
        begin
            u0 = pick_tex();
            v0 = pick_tex();
            send_corner(pick_pos(), pick_pos(), pick_pos(), u0, v0);
            // one in eight repeats a texture coordinate: degenerate triangle
            if ($urandom_range(0, 7) == 0)
            begin
                send_corner(pick_pos(), pick_pos(), pick_pos(), u0, v0);
                send_corner(pick_pos(), pick_pos(), pick_pos(), pick_tex(), pick_tex());
            end
            else
            begin
                send_corner(pick_pos(), pick_pos(), pick_pos(), pick_tex(), pick_tex());
                send_corner(pick_pos(), pick_pos(), pick_pos(), pick_tex(), pick_tex());
            end
        end
    endtask

    // Result side: random stalls, plus the long hold-off when asked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_result({tangent_x, tangent_y, tangent_z,
                                 bitangent_x, bitangent_y, bitangent_z,
                                 degenerate, saturated});
            if (hold_req && !hold_taken)
            begin
                hold_taken <= 1'b1;
                hold_cycles <= 3000;
                out_ready <= 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles <= hold_cycles - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unit triangle, degenerate, saturating, extremes.
        send_corner('0, '0, '0, '0, '0);
        send_corner(PW'(1 << 16), '0, '0, TW'(1 << 16), '0);
        send_corner('0, PW'(1 << 16), '0, '0, TW'(1 << 16));
        // zero determinant: all texture coordinates equal
        send_corner(PW'(5), PW'(6), PW'(7), TW'(3), TW'(3));
        send_corner(PW'(9), PW'(1), PW'(2), TW'(3), TW'(3));
        send_corner(PW'(4), PW'(8), PW'(0), TW'(3), TW'(3));
        // huge positions over a tiny determinant saturate both ways
        send_corner({1'b1, {(PW-1){1'b0}}}, {1'b0, {(PW-1){1'b1}}}, '0, '0, '0);
        send_corner({1'b0, {(PW-1){1'b1}}}, {1'b1, {(PW-1){1'b0}}}, '1, TW'(1), '0);
        send_corner({1'b1, {(PW-1){1'b0}}}, '1, {1'b0, {(PW-1){1'b1}}}, '0, TW'(1));
        // texture extremes: largest determinant
        send_corner('1, '1, '1, {1'b1, {(TW-1){1'b0}}}, {1'b1, {(TW-1){1'b0}}});
        send_corner('0, '1, '0, {1'b0, {(TW-1){1'b1}}}, {1'b1, {(TW-1){1'b0}}});
        send_corner('1, '0, '0, {1'b1, {(TW-1){1'b0}}}, {1'b0, {(TW-1){1'b1}}});

        // Long stall on the result side while corners keep coming.
        hold_req = 1'b1;
        send_random_triangles(6);

        send_random_triangles(70);
        send_idle_pct = 69;
        recv_idle_pct = 35;
        send_random_triangles(70);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_random_triangles(70);
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        wait (stim_done);
        while (sb.pending.size() != 0)
            @(posedge clk);
        // give a margin for stray output
        repeat (1200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Worst case about 220 triangles at 69% stall, plus the hold-off.
    initial
    begin
        #30000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[filelist.f]
sv/ttb_pkg.sv
sv/ttb_mul.sv
sv/ttb_div.sv
sv/triangle_tangent_bitangent.sv
sv/ttb_checker.sv
verif/triangle_tangent_bitangent_tb.sv
